// ===== hdl/esf_pkg.sv =====
// ----------------------------------------------------------------------------
// esf_pkg
// Shared types, constants and saturation helper for the elastic stress flux
// pipeline.
// ----------------------------------------------------------------------------
package esf_pkg;

    localparam int ESF_FRAC_BITS = 16;
    localparam int ESF_W         = 32;

    typedef enum logic {
        MODE_PSV = 1'b0,
        MODE_SH  = 1'b1
    } t_wave_mode;

    typedef struct packed {
        logic signed [ESF_W-1:0] grad_ux_x;
        logic signed [ESF_W-1:0] grad_ux_z;
        logic signed [ESF_W-1:0] grad_uz_x;
        logic signed [ESF_W-1:0] grad_uz_z;
        logic signed [ESF_W-1:0] lam_plus_2mu;
        logic signed [ESF_W-1:0] shear_mod;
        logic signed [ESF_W-1:0] dxi_dx;
        logic signed [ESF_W-1:0] dxi_dz;
        logic signed [ESF_W-1:0] dgamma_dx;
        logic signed [ESF_W-1:0] dgamma_dz;
        logic signed [ESF_W-1:0] jac_det;
    } t_in_word;

    typedef struct packed {
        logic signed [ESF_W-1:0] flux_x_xi;
        logic signed [ESF_W-1:0] flux_z_xi;
        logic signed [ESF_W-1:0] flux_x_gamma;
        logic signed [ESF_W-1:0] flux_z_gamma;
    } t_out_word;

    localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
    localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

    // Clamp to the signed 32-bit range.
    function automatic logic signed [ESF_W-1:0] sat32(input logic signed [64:0] v);
        logic signed [ESF_W-1:0] res;
        if (v > SAT_MAX) begin
            res = SAT_MAX[ESF_W-1:0];
        end else if (v < SAT_MIN) begin
            res = SAT_MIN[ESF_W-1:0];
        end else begin
            res = v[ESF_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/esf_stream_if.sv =====
// ----------------------------------------------------------------------------
// esf_stream_if
// Valid/ready stream channel carrying one word of type T_WORD.
// ----------------------------------------------------------------------------
interface esf_stream_if #(
    parameter type T_WORD = logic
);
    logic  valid;
    logic  ready;
    T_WORD data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/elastic_stress_flux_2d_unit.sv =====
// ----------------------------------------------------------------------------
// elastic_stress_flux_2d_unit
// Pipeline: nine register stages (lambda, stress multiply, round, stress sum,
//   flux multiply, round, inner sum, Jacobian multiply, round and saturate).
// Throughput: one word per cycle; every stage holds under back-pressure.
// Reset: synchronous active-low i_rst_n clears all stage valid bits and
//   sets wave_mode to P-SV; data registers are not reset.
// ----------------------------------------------------------------------------
module elastic_stress_flux_2d_unit
    import esf_pkg::*;
#(
    parameter int FRAC_BITS = ESF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    esf_stream_if.sink          i_in,
    esf_stream_if.source        o_out
);

    // Product width and width of a product after rounding off FRAC_BITS.
    localparam int PW  = 2 * ESF_W;
    localparam int RW  = PW - FRAC_BITS;
    localparam int NST = 9;
    localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (FRAC_BITS - 1));

    typedef logic signed [ESF_W-1:0] t_q;
    typedef logic signed [PW-1:0]    t_prod;
    typedef logic signed [RW-1:0]    t_rnd;

    typedef struct packed {
        t_q xix;
        t_q xiz;
        t_q gax;
        t_q gaz;
        t_q jac;
    } t_geom;

    // Round half toward plus infinity: add half an LSB, then floor-shift.
    function automatic t_rnd rnd(input t_prod p);
        t_prod t;
        t = p + HALF;
        return $signed(t[PW-1:FRAC_BITS]);
    endfunction

    // ------------------------------------------------------------------
    // Configuration: single mode bit; the user must write it only while the pipe is idle (not enforced).
    // ------------------------------------------------------------------
    t_wave_mode r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PSV;
        end else if (i_cfg_we) begin
            r_mode <= t_wave_mode'(i_cfg_wdata);
        end
    end

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its word moves on.
    // ------------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || o_out.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the word, form lambda = sat(l2m - 2*mu).
    // ------------------------------------------------------------------
    t_in_word   r_s1_in;
    t_q         r_s1_lam;
    t_wave_mode r_s1_mode;
    t_q         n_s1_lam;

    always_comb begin
        n_s1_lam = sat32(65'(i_in.data.lam_plus_2mu) - 65'(i_in.data.shear_mod) -
                         65'(i_in.data.shear_mod));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_in   <= i_in.data;
            r_s1_lam  <= n_s1_lam;
            r_s1_mode <= r_mode;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: six stress products. In SH mode zero the operands that
    // must not contribute, so the rounded terms vanish downstream.
    //   0: l2m*gxx (mu*gxx in SH)  1: lam*gzz   -> sxx
    //   2: l2m*gzz                 3: lam*gxx   -> szz
    //   4: mu*gxz                  5: mu*gzx    -> sxz
    // ------------------------------------------------------------------
    t_prod r_s2_p [6];
    t_prod n_s2_p [6];
    t_geom r_s2_geo;
    t_q    w_s2_a0;
    t_q    w_s2_lam;
    t_q    w_s2_l2m;
    t_q    w_s2_mu5;

    always_comb begin
        if (r_s1_mode == MODE_SH) begin
            w_s2_a0  = r_s1_in.shear_mod;
            w_s2_lam = '0;
            w_s2_l2m = '0;
            w_s2_mu5 = '0;
        end else begin
            w_s2_a0  = r_s1_in.lam_plus_2mu;
            w_s2_lam = r_s1_lam;
            w_s2_l2m = r_s1_in.lam_plus_2mu;
            w_s2_mu5 = r_s1_in.shear_mod;
        end
        n_s2_p[0] = w_s2_a0  * r_s1_in.grad_ux_x;
        n_s2_p[1] = w_s2_lam * r_s1_in.grad_uz_z;
        n_s2_p[2] = w_s2_l2m * r_s1_in.grad_uz_z;
        n_s2_p[3] = w_s2_lam * r_s1_in.grad_ux_x;
        n_s2_p[4] = r_s1_in.shear_mod * r_s1_in.grad_ux_z;
        n_s2_p[5] = w_s2_mu5 * r_s1_in.grad_uz_x;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_p   <= n_s2_p;
            r_s2_geo <= '{xix: r_s1_in.dxi_dx, xiz: r_s1_in.dxi_dz,
                          gax: r_s1_in.dgamma_dx, gaz: r_s1_in.dgamma_dz,
                          jac: r_s1_in.jac_det};
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round the stress products.
    // ------------------------------------------------------------------
    t_rnd  r_s3_r [6];
    t_geom r_s3_geo;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int k = 0; k < 6; k++) begin
                r_s3_r[k] <= rnd(r_s2_p[k]);
            end
            r_s3_geo <= r_s2_geo;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: stress sums, saturated.
    // ------------------------------------------------------------------
    t_q    r_s4_sxx;
    t_q    r_s4_szz;
    t_q    r_s4_sxz;
    t_geom r_s4_geo;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_sxx <= sat32(65'(r_s3_r[0]) + 65'(r_s3_r[1]));
            r_s4_szz <= sat32(65'(r_s3_r[2]) + 65'(r_s3_r[3]));
            r_s4_sxz <= sat32(65'(r_s3_r[4]) + 65'(r_s3_r[5]));
            r_s4_geo <= r_s3_geo;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: eight mapping products, in pairs per flux term.
    // ------------------------------------------------------------------
    t_prod r_s5_p [8];
    t_prod n_s5_p [8];
    t_q    r_s5_jac;

    always_comb begin
        n_s5_p[0] = r_s4_sxx * r_s4_geo.xix;
        n_s5_p[1] = r_s4_sxz * r_s4_geo.xiz;
        n_s5_p[2] = r_s4_sxz * r_s4_geo.xix;
        n_s5_p[3] = r_s4_szz * r_s4_geo.xiz;
        n_s5_p[4] = r_s4_sxx * r_s4_geo.gax;
        n_s5_p[5] = r_s4_sxz * r_s4_geo.gaz;
        n_s5_p[6] = r_s4_sxz * r_s4_geo.gax;
        n_s5_p[7] = r_s4_szz * r_s4_geo.gaz;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_p   <= n_s5_p;
            r_s5_jac <= r_s4_geo.jac;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: round the mapping products.
    // ------------------------------------------------------------------
    t_rnd r_s6_r [8];
    t_q   r_s6_jac;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int k = 0; k < 8; k++) begin
                r_s6_r[k] <= rnd(r_s5_p[k]);
            end
            r_s6_jac <= r_s5_jac;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: inner sums, saturated.
    // ------------------------------------------------------------------
    t_q r_s7_in [4];
    t_q r_s7_jac;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int k = 0; k < 4; k++) begin
                r_s7_in[k] <= sat32(65'(r_s6_r[2*k]) + 65'(r_s6_r[2*k+1]));
            end
            r_s7_jac <= r_s6_jac;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: Jacobian weighting.
    // ------------------------------------------------------------------
    t_prod r_s8_p [4];
    t_prod n_s8_p [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_s8_p[k] = r_s7_jac * r_s7_in[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s8_p <= n_s8_p;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: round and saturate into the output register; hold it while
    // the sink stalls.
    // ------------------------------------------------------------------
    t_out_word r_s9_out;

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_s9_out.flux_x_xi    <= sat32(65'(rnd(r_s8_p[0])));
            r_s9_out.flux_z_xi    <= sat32(65'(rnd(r_s8_p[1])));
            r_s9_out.flux_x_gamma <= sat32(65'(rnd(r_s8_p[2])));
            r_s9_out.flux_z_gamma <= sat32(65'(rnd(r_s8_p[3])));
        end
    end

    assign o_out.valid = r_vld[NST-1];
    assign o_out.data  = r_s9_out;

endmodule

// ===== sim/elastic_stress_flux_2d_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elastic_stress_flux_2d_unit_tb
// Self-checking bench for the 2D elastic stress flux pipeline. A short table
// of hand-picked quadrature points runs first, then randomized points in
// phases of both wave modes with varying sender gaps and receiver stalls.
// Every output word is checked field by field against its typed-in word or an
// in-bench Q16.16 model of the stress law and the Jacobian-weighted flux terms.
// ----------------------------------------------------------------------------
module elastic_stress_flux_2d_unit_tb;
    import esf_pkg::*;

    // Nine register stages between input accept and output valid.
    localparam int PIPE_LATENCY = 9;
    // Long receiver hold-off, well past the pipeline depth.
    localparam int HOLD_CYCLES  = 48;
    localparam int CYCLE_LIMIT  = 200_000;

    localparam logic [31:0] Q_ZERO     = 32'h0000_0000;
    localparam logic [31:0] Q_ONE      = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE  = 32'hffff_0000;
    localparam logic [31:0] Q_MAX      = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN      = 32'h8000_0000;
    localparam logic [31:0] Q_LSB      = 32'h0000_0001;
    localparam logic [31:0] Q_NEG_LSB  = 32'hffff_ffff;
    // Times one raw LSB, this lands exactly on half an output LSB.
    localparam logic [31:0] Q_HALF_LSB = 32'h0000_8000;

    localparam longint Q_SAT_HI = 64'sd2147483647;
    localparam longint Q_SAT_LO = -64'sd2147483648;

    typedef struct {
        t_wave_mode mode;
        t_in_word   pt;
        bit         typed;   // expected word typed in below
        t_out_word  want;
    } t_stim_row;

    typedef struct {
        t_wave_mode mode;
        int         idle_pct;   // sender gap probability, percent
        int         stall;      // receiver stall probability, percent
        int         words;
        bit         hold_off;   // long receiver hold-off mid-phase
        bit         pause;      // sender waits for the pipe to empty mid-phase
    } t_phase;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    esf_stream_if #(.T_WORD(t_in_word))  pt_if ();
    esf_stream_if #(.T_WORD(t_out_word)) flux_if ();

    elastic_stress_flux_2d_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (pt_if),
        .o_out       (flux_if)
    );

    t_out_word  flux_due [$];      // predicted words, oldest first
    t_stim_row  stim_table [$];
    t_phase     phase_plan [6];
    t_wave_mode mode_now = MODE_PSV;   // register value after reset
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    bit         hold_req = 1'b0;
    int         err_cnt = 0;
    int         cycle_cnt = 0;

    // ------------------------------------------------------------------
    // Q16.16 model of the datapath
    // ------------------------------------------------------------------
    function automatic longint clamp32(input longint v);
        if (v > Q_SAT_HI) return Q_SAT_HI;
        if (v < Q_SAT_LO) return Q_SAT_LO;
        return v;
    endfunction

    // Exact product, add half an LSB, then floor shift: ties go toward +inf.
    function automatic longint qmul(input longint a, input longint b);
        longint prod;
        prod = a * b + (longint'(1) <<< (ESF_FRAC_BITS - 1));
        return prod >>> ESF_FRAC_BITS;
    endfunction

    function automatic longint flux_term(input longint jac, input longint s1,
                                         input longint m1, input longint s2,
                                         input longint m2);
        return clamp32(qmul(jac, clamp32(qmul(s1, m1) + qmul(s2, m2))));
    endfunction

    function automatic t_out_word calc_flux(input t_wave_mode m, input t_in_word w);
        longint gxx, gxz, gzx, gzz, l2m, mu, lam;
        longint xix, xiz, gax, gaz, jac;
        longint sxx, szz, sxz;
        t_out_word r;
        gxx = $signed(w.grad_ux_x);
        gxz = $signed(w.grad_ux_z);
        gzx = $signed(w.grad_uz_x);
        gzz = $signed(w.grad_uz_z);
        l2m = $signed(w.lam_plus_2mu);
        mu  = $signed(w.shear_mod);
        xix = $signed(w.dxi_dx);
        xiz = $signed(w.dxi_dz);
        gax = $signed(w.dgamma_dx);
        gaz = $signed(w.dgamma_dz);
        jac = $signed(w.jac_det);
        if (m == MODE_PSV) begin
            lam = clamp32(l2m - 2 * mu);
            sxx = clamp32(qmul(l2m, gxx) + qmul(lam, gzz));
            szz = clamp32(qmul(l2m, gzz) + qmul(lam, gxx));
            sxz = clamp32(qmul(mu, gxz) + qmul(mu, gzx));
        end else begin
            // Antiplane shear: no lambda, no normal stress along z.
            sxx = clamp32(qmul(mu, gxx));
            sxz = clamp32(qmul(mu, gxz));
            szz = 0;
        end
        r.flux_x_xi    = 32'(flux_term(jac, sxx, xix, sxz, xiz));
        r.flux_z_xi    = 32'(flux_term(jac, sxz, xix, szz, xiz));
        r.flux_x_gamma = 32'(flux_term(jac, sxx, gax, sxz, gaz));
        r.flux_z_gamma = 32'(flux_term(jac, sxz, gax, szz, gaz));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in_word mk_point(
        input logic [31:0] gxx, input logic [31:0] gxz, input logic [31:0] gzx,
        input logic [31:0] gzz, input logic [31:0] l2m, input logic [31:0] mu,
        input logic [31:0] xix, input logic [31:0] xiz, input logic [31:0] gax,
        input logic [31:0] gaz, input logic [31:0] jac);
        return {gxx, gxz, gzx, gzz, l2m, mu, xix, xiz, gax, gaz, jac};
    endfunction

    task automatic add_row(input t_wave_mode m, input t_in_word w,
                           input bit typed = 1'b0, input t_out_word want = '0);
        t_stim_row row;
        row.mode  = m;
        row.pt    = w;
        row.typed = typed;
        row.want  = want;
        stim_table.push_back(row);
    endtask

    // Small magnitudes most often, so the stresses stay unsaturated, then full
    // range words and a sprinkle of corner values.
    function automatic logic [31:0] rand_field();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        if (sel < 85) return $urandom();
        case ($urandom_range(0, 6))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return Q_ZERO;
            3: return Q_ONE;
            4: return Q_NEG_ONE;
            5: return Q_HALF_LSB;
            default: return Q_NEG_LSB;
        endcase
    endfunction

    function automatic t_in_word random_point();
        t_in_word w;
        for (int k = 0; k < 11; k++) w[k*32 +: 32] = rand_field();
        return w;
    endfunction

    // Offer one word, with random gaps ahead of it; log the prediction at accept.
    task automatic send_point(input t_in_word w, input bit typed, input t_out_word want);
        t_out_word e;
        e = typed ? want : calc_flux(mode_now, w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.data  <= w;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
        flux_due.push_back(e);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every predicted word has come out.
    task automatic drain_flux();
        pt_if.valid <= 1'b0;
        @(negedge i_clk);
        while (flux_due.size() != 0) @(negedge i_clk);
    endtask

    // Write the mode register only with the pipe empty.
    task automatic set_mode(input t_wave_mode m);
        drain_flux();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_now     = m;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle guard
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off on request so the pipe
    // backs up into the input.
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        flux_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                flux_if.ready <= 1'b0;
                hold_left--;
            end else begin
                flux_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output checker: compare each accepted word with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && flux_if.valid && flux_if.ready) begin
            if (flux_due.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected flux word, expected none, got %h",
                         $time, flux_if.data);
            end else begin
                want = flux_due.pop_front();
                check_field("flux_x_xi",    want.flux_x_xi,    flux_if.data.flux_x_xi);
                check_field("flux_z_xi",    want.flux_z_xi,    flux_if.data.flux_z_xi);
                check_field("flux_x_gamma", want.flux_x_gamma, flux_if.data.flux_x_gamma);
                check_field("flux_z_gamma", want.flux_z_gamma, flux_if.data.flux_z_gamma);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        pt_if.valid = 1'b0;
        pt_if.data  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        i_rst_n     = 1'b0;

        // --- directed table; rows without a typed word go to the model ---
        // All zero in the reset mode: nothing but zeros out.
        add_row(MODE_PSV, mk_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                                   Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO),
                1'b1, {Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO});
        // Unit cell: lambda = mu = 1, uniform dilation.
        add_row(MODE_PSV, mk_point(Q_ONE, Q_ZERO, Q_ZERO, Q_ONE, 32'h0003_0000, Q_ONE,
                                   Q_ONE, Q_ZERO, Q_ZERO, Q_ONE, Q_ONE));
        add_row(MODE_PSV, mk_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                   Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        add_row(MODE_PSV, mk_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                   Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        // Lambda saturates low, then high.
        add_row(MODE_PSV, mk_point(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_MIN, Q_MAX,
                                   Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        add_row(MODE_PSV, mk_point(Q_ONE, Q_NEG_ONE, Q_ONE, Q_NEG_ONE, Q_MAX, Q_MIN,
                                   Q_ONE, Q_NEG_ONE, Q_ONE, Q_NEG_ONE, Q_ONE));
        // Rounding ties: positive half goes up, negative half goes to zero.
        add_row(MODE_PSV, mk_point(Q_HALF_LSB, Q_ZERO, Q_ZERO, Q_ZERO, Q_LSB, Q_ZERO,
                                   Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE));
        add_row(MODE_PSV, mk_point(Q_HALF_LSB, Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG_LSB, Q_ZERO,
                                   Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE));
        // Shear stress saturates, negative Jacobian.
        add_row(MODE_PSV, mk_point(Q_ZERO, Q_MAX, Q_MAX, Q_ZERO, Q_ZERO, Q_MAX,
                                   Q_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_NEG_ONE));

        // Antiplane shear rows.
        add_row(MODE_SH, mk_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                                  Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO),
                1'b1, {Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO});
        // Flux pinned at the top, then at the bottom.
        add_row(MODE_SH, mk_point(Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX,
                                  Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX),
                1'b1, {Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO});
        add_row(MODE_SH, mk_point(Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX,
                                  Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX),
                1'b1, {Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO});
        // Unit shear: sxx = sxz = 1, szz forced to zero.
        add_row(MODE_SH, mk_point(Q_ONE, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE,
                                  Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE),
                1'b1, {32'h0002_0000, Q_ONE, 32'h0002_0000, Q_ONE});
        // Lambda input ignored here, even at its extremes.
        add_row(MODE_SH, mk_point(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                  Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        add_row(MODE_SH, mk_point(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                  Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        add_row(MODE_SH, mk_point(Q_ONE, Q_NEG_ONE, Q_MAX, Q_MIN, Q_MIN, Q_ONE,
                                  Q_ONE, Q_ONE, Q_NEG_ONE, Q_ONE, Q_NEG_ONE));
        add_row(MODE_SH, mk_point(Q_HALF_LSB, Q_NEG_LSB, Q_ZERO, Q_ZERO, Q_ZERO, Q_LSB,
                                  Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));

        // Back to in-plane: mixed signs across the extremes.
        add_row(MODE_PSV, mk_point(Q_MAX, Q_MIN, Q_ONE, Q_MIN, Q_ONE, Q_NEG_ONE,
                                   Q_MIN, Q_MAX, Q_HALF_LSB, Q_NEG_ONE, Q_MAX));
        add_row(MODE_PSV, mk_point(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                                   Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO),
                1'b1, {Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO});

        // --- random phases: mode, sender gaps, receiver stalls ---
        phase_plan = '{
            '{MODE_PSV,  0,  0, 250, 1'b1, 1'b0},
            '{MODE_SH,  87,  0, 250, 1'b0, 1'b0},
            '{MODE_PSV,  0, 87, 250, 1'b0, 1'b1},
            '{MODE_SH,   6,  6, 250, 1'b0, 1'b1},
            '{MODE_SH,   0,  0, 250, 1'b1, 1'b0},
            '{MODE_PSV,  6,  6, 250, 1'b0, 1'b0}
        };

        // Hold reset, then release it on a falling edge.
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table; rewrite the mode only where it changes.
        foreach (stim_table[k]) begin
            if (stim_table[k].mode != mode_now) set_mode(stim_table[k].mode);
            send_point(stim_table[k].pt, stim_table[k].typed, stim_table[k].want);
        end

        foreach (phase_plan[p]) begin
            set_mode(phase_plan[p].mode);
            send_idle_pct = phase_plan[p].idle_pct;
            stall_pct     = phase_plan[p].stall;
            for (int n = 0; n < phase_plan[p].words; n++) begin
                // Stall the output for a long stretch while words keep coming.
                if (phase_plan[p].hold_off && n == 60) hold_req = 1'b1;
                // Pause the sender until the pipe has emptied.
                if (phase_plan[p].pause && n == 120) drain_flux();
                send_point(random_point(), 1'b0, '0);
            end
        end

        // Let the pipe empty, then give stray words time to show up.
        drain_flux();
        repeat (PIPE_LATENCY + 4) @(negedge i_clk);

        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/esf_pkg.sv
hdl/esf_stream_if.sv
hdl/elastic_stress_flux_2d_unit.sv
sim/elastic_stress_flux_2d_unit_tb.sv
